// File: sv/hgsm_pkg.sv
// shared types, codes and font tables for the hangul glyph slot mapper
package hgsm_pkg;

    // default geometry of the slot map
    localparam int unsigned SLOTS_DEF      = 105;
    localparam int unsigned FIRST_SLOT_DEF = 151;

    // hangul syllable block
    localparam logic [20:0] HANGUL_FIRST = 21'h00AC00;
    localparam logic [20:0] HANGUL_LAST  = 21'h00D7A3;

    // reciprocals for division by 28 and by 21
    localparam logic [14:0] RECIP_28  = 15'd18725;
    localparam int unsigned SHIFT_28  = 19;
    localparam logic [8:0]  RECIP_21  = 9'd391;
    localparam int unsigned SHIFT_21  = 13;

    // request operation codes
    typedef enum logic [1:0] {
        OP_TEXT  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY_LD,
        ST_DEC1,
        ST_DEC2,
        ST_SEARCH,
        ST_RAW_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
        logic       end_of_string;
    } request_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_slot;
        logic        newly_allocated;
        logic [15:0] code_point;
        logic [4:0]  onset_index;
        logic [2:0]  onset_variant;
        logic        nucleus_set;
        logic [4:0]  nucleus_index;
        logic [4:0]  coda_index;
        logic        last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_query;
        logic dec1;
        logic dec2;
        logic search_run;
        logic load_hit;
        logic load_miss;
        logic load_raw;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_query;
        logic start_hangul;
        logic start_raw;
        logic hit;
        logic miss;
        logic out_last;
    } status_t;

    // vowel font lookup
    localparam logic [4:0] VOWEL_LOOKUP [21] = '{
        5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd26, 5'd27, 5'd28, 5'd29
    };

    // final consonant font lookup
    localparam logic [4:0] FINAL_LOOKUP [28] = '{
        5'd0, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd19, 5'd20,
        5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29
    };

    // vowel shape class for onset variant
    localparam logic [1:0] VOWEL_CLASS [21] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0
    };

    // sequence length from a lead byte
    function automatic logic [2:0] lead_need(input logic [7:0] b);
        logic [2:0] n;
        if (b[7] == 1'b0)
            n = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

endpackage

// File: sv/hgsm_req_if.sv
// request channel: valid, ready and one request payload
interface hgsm_req_if
    import hgsm_pkg::*;
    ();
    logic     valid;
    logic     ready;
    request_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/hgsm_res_if.sv
// result channel: valid, ready and one result payload
interface hgsm_res_if
    import hgsm_pkg::*;
    ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/hgsm_ctrl.sv
// controller state machine of the hangul glyph slot mapper
module hgsm_ctrl
    import hgsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.start_query)
                        state_next = ST_QUERY_LD;
                    else if (status.start_hangul)
                        state_next = ST_DEC1;
                    else if (status.start_raw)
                        state_next = ST_RAW_LD;
                end
            end
            ST_QUERY_LD: state_next = ST_OUT_WAIT;
            ST_DEC1:     state_next = ST_DEC2;
            ST_DEC2:     state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (status.hit || status.miss)
                    state_next = ST_OUT_WAIT;
            end
            ST_RAW_LD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (out_ready)
                    state_next = status.out_last ? ST_IDLE : ST_RAW_LD;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_QUERY_LD: cmd.load_query = 1'b1;
            ST_DEC1:     cmd.dec1 = 1'b1;
            ST_DEC2:     cmd.dec2 = 1'b1;
            ST_SEARCH:
            begin
                cmd.search_run = 1'b1;
                cmd.load_hit   = status.hit;
                cmd.load_miss  = !status.hit && status.miss;
            end
            ST_RAW_LD:   cmd.load_raw = 1'b1;
            ST_OUT_WAIT: out_valid = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

// File: sv/hgsm_datapath.sv
// datapath: utf-8 assembly, slot map memory, search and jamo decode
module hgsm_datapath
    import hgsm_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned FIRST_SLOT = FIRST_SLOT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  request_t req,
    input  cmd_t     cmd,
    output status_t  status,
    output result_t  result
);

    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [7:0] FIRST_C = 8'(FIRST_SLOT);

    // sequence state
    logic [7:0] bytes_reg [4];
    logic [2:0] have_reg, have_next;
    logic [2:0] need_reg, need_next;

    // map counters
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [IDX_W-1:0] repl_reg, repl_next;

    // slot memory
    logic [15:0]      mem [SLOTS];
    logic [15:0]      rdata_reg;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    // search pipeline
    logic [CNT_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg;
    logic             issue;

    // current item
    logic [20:0] cp_reg;
    logic [2:0]  raw_count_reg;
    logic [1:0]  raw_idx_reg;
    logic [7:0]  qbyte_reg;
    logic        qvalid_reg;

    // jamo decode pipeline
    logic [8:0] q28_reg;
    logic [4:0] fin_reg;
    logic [4:0] ini_reg;
    logic [4:0] vow_reg;

    result_t result_reg;

    // sequence assembly on an accepted text byte
    logic [2:0]  need_eff;
    logic [2:0]  have_inc;
    logic        seq_done;
    logic [7:0]  sb [4];
    logic [20:0] cp_new;
    logic        is_hangul;
    logic        is_text;

    always_comb
    begin
        is_text  = (req.op == OP_TEXT);
        need_eff = (have_reg == 3'd0) ? lead_need(req.in_byte) : need_reg;
        have_inc = have_reg + 3'd1;
        seq_done = (have_inc >= need_eff);
        for (int k = 0; k < 4; k++)
            sb[k] = (have_reg[1:0] == 2'(k)) ? req.in_byte : bytes_reg[k];
        case (need_eff)
            3'd2:    cp_new = {10'd0, sb[0][4:0], sb[1][5:0]};
            3'd3:    cp_new = {5'd0, sb[0][3:0], sb[1][5:0], sb[2][5:0]};
            3'd4:    cp_new = {sb[0][2:0], sb[1][5:0], sb[2][5:0], sb[3][5:0]};
            default: cp_new = {13'd0, sb[0]};
        endcase
        is_hangul = seq_done && (cp_new >= HANGUL_FIRST) && (cp_new <= HANGUL_LAST);
    end

    always_comb
    begin
        have_next = have_reg;
        need_next = need_reg;
        if (cmd.accept && is_text)
        begin
            if (seq_done || req.end_of_string)
            begin
                have_next = 3'd0;
                need_next = 3'd0;
            end
            else
            begin
                have_next = have_inc;
                need_next = need_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 3'd0;
            need_reg <= 3'd0;
        end
        else
        begin
            have_reg <= have_next;
            need_reg <= need_next;
        end
    end

    // sequence bytes and per-item capture
    logic [8:0] qoff;
    logic       qin;

    always_comb
    begin
        qoff = {1'b0, req.in_byte} - {1'b0, FIRST_C};
        qin  = (req.in_byte >= FIRST_C) && (qoff < 9'(filled_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_text)
        begin
            bytes_reg[have_reg[1:0]] <= req.in_byte;
            cp_reg                   <= cp_new;
            raw_count_reg            <= have_inc;
        end
        if (cmd.accept)
        begin
            qbyte_reg <= req.in_byte;
            qvalid_reg <= qin;
        end
    end

    // raw byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            raw_idx_reg <= 2'd0;
        else if (cmd.accept)
            raw_idx_reg <= 2'd0;
        else if (cmd.load_raw)
            raw_idx_reg <= raw_idx_reg + 2'd1;
    end

    // jamo decode, divide by 28 then by 21
    logic [13:0] base;
    logic [28:0] prod28;
    logic [8:0]  q28;
    logic [17:0] prod21;
    logic [4:0]  ini;

    always_comb
    begin
        base   = 14'(cp_reg - HANGUL_FIRST);
        prod28 = 29'(base) * 29'(RECIP_28);
        q28    = 9'(prod28 >> SHIFT_28);
        prod21 = 18'(q28_reg) * 18'(RECIP_21);
        ini    = 5'(prod21 >> SHIFT_21);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dec1)
        begin
            q28_reg <= q28;
            fin_reg <= 5'(base - 14'(q28) * 14'd28);
        end
        if (cmd.dec2)
        begin
            ini_reg <= ini;
            vow_reg <= 5'(q28_reg - 9'(ini) * 9'd21);
        end
    end

    // search pipeline: one entry read per cycle, compared against the registered read data in the following cycle
    logic hit;
    logic miss;

    always_comb
    begin
        hit   = cmp_valid_reg && (rdata_reg == cp_reg[15:0]);
        miss  = !cmp_valid_reg && (rd_idx_reg == filled_reg);
        issue = cmd.search_run && !hit && (rd_idx_reg < filled_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= issue;
            if (issue)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
    end

    // slot memory port control
    logic [IDX_W-1:0] alloc_idx;
    logic             not_full;

    always_comb
    begin
        not_full  = (filled_reg < SLOTS_C);
        alloc_idx = not_full ? filled_reg[IDX_W-1:0] : repl_reg;
        mem_we    = cmd.load_miss;
        mem_waddr = alloc_idx;
        mem_re    = issue || (cmd.accept && req.op == OP_QUERY);
        mem_raddr = issue ? rd_idx_reg[IDX_W-1:0] : qoff[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= cp_reg[15:0];
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // fill count and round robin pointer
    always_comb
    begin
        filled_next = filled_reg;
        repl_next   = repl_reg;
        if (cmd.accept && req.op == OP_CLEAR)
        begin
            filled_next = '0;
            repl_next   = '0;
        end
        else if (cmd.load_miss)
        begin
            if (not_full)
                filled_next = filled_reg + 1'b1;
            else if (32'(repl_reg) == SLOTS - 1)
                repl_next = '0;
            else
                repl_next = repl_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            repl_reg   <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            repl_reg   <= repl_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            result_reg            <= '0;
            result_reg.out_byte   <= qbyte_reg;
            result_reg.code_point <= qvalid_reg ? rdata_reg : 16'd0;
            result_reg.last       <= 1'b1;
        end
        else if (cmd.load_raw)
        begin
            result_reg          <= '0;
            result_reg.out_byte <= bytes_reg[raw_idx_reg];
            result_reg.last     <= (3'(raw_idx_reg) == raw_count_reg - 3'd1);
        end
        else if (cmd.load_hit)
        begin
            result_reg            <= '0;
            result_reg.out_byte   <= 8'(FIRST_C + 8'(cmp_idx_reg));
            result_reg.is_slot    <= 1'b1;
            result_reg.code_point <= cp_reg[15:0];
            result_reg.last       <= 1'b1;
        end
        else if (cmd.load_miss)
        begin
            result_reg.out_byte        <= 8'(FIRST_C + 8'(alloc_idx));
            result_reg.is_slot         <= 1'b1;
            result_reg.newly_allocated <= 1'b1;
            result_reg.code_point      <= cp_reg[15:0];
            result_reg.onset_index     <= 5'(ini_reg + 5'd2);
            result_reg.onset_variant   <= 3'(VOWEL_CLASS[vow_reg])
                                          + ((fin_reg != 5'd0) ? 3'd3 : 3'd0);
            result_reg.nucleus_set     <= (fin_reg != 5'd0);
            result_reg.nucleus_index   <= VOWEL_LOOKUP[vow_reg];
            result_reg.coda_index      <= FINAL_LOOKUP[fin_reg];
            result_reg.last            <= 1'b1;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.start_query  = (req.op == OP_QUERY);
        status.start_hangul = is_text && is_hangul;
        status.start_raw    = is_text && !is_hangul && (seq_done || req.end_of_string);
        status.hit          = hit;
        status.miss         = miss;
        status.out_last     = result_reg.last;
    end

    assign result = result_reg;

endmodule

// File: sv/hangul_glyph_slot_mapper.sv
// top level of the hangul glyph slot mapper
//
// request channel carries op, in_byte and end_of_string; result channel
// carries one result per transfer, last marking the final one of a request.
// text bytes are assembled into utf-8 sequences; a hangul syllable gives one
// slot result, anything else its raw bytes; a query gives the code point of
// a slot, a clear empties the slot map and gives nothing.
// one request is worked at a time; ready is high only when idle.
// a byte that ends nothing gives no result; a raw result is loaded in the
// RAW_LD state and a query result in QUERY_LD; a syllable passes the decode
// states DEC1 and DEC2, then a search through the registered read and
// compare at one filled slot per cycle, set by the one read port of the
// slot memory.
// reset empties the map (fill count, round robin pointer) and drops any
// partial sequence; memory contents are not cleared, the fill count hides them.
// while the receiver stalls the result is held and no request is taken.
module hangul_glyph_slot_mapper
    import hgsm_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned FIRST_SLOT = FIRST_SLOT_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    hgsm_req_if.sink   request,
    hgsm_res_if.source result
);

    cmd_t    cmd;
    status_t status;

    // controller
    hgsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    hgsm_datapath #(
        .SLOTS      (SLOTS),
        .FIRST_SLOT (FIRST_SLOT)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (request.payload),
        .cmd    (cmd),
        .status (status),
        .result (result.payload)
    );

    // one request at a time: never ready while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        !(request.ready && result.valid))
        else $error("request taken while a result is pending");

    // a query answers once the QUERY_LD state has loaded its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.payload.op == OP_QUERY)
        |-> ##2 result.valid)
        else $error("query result missing");

    // a new allocation is always a slot result ending its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.newly_allocated)
        |-> (result.payload.is_slot && result.payload.last))
        else $error("allocation without slot flag");

    // clear requests give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.payload.op == OP_CLEAR)
        |=> !result.valid)
        else $error("clear gave a result");

endmodule

// File: dv/hgsm_slot_checker.sv
// checker that predicts and compares slot mapper results on the two channels
`timescale 1ns / 100ps
module hgsm_slot_checker
    import hgsm_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned FIRST_SLOT = FIRST_SLOT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  request_t    req_payload,
    input  logic        res_valid,
    input  logic        res_ready,
    input  result_t     res_payload,
    output int          fail_count,
    output int          pending_count,
    output int          slot_results,
    output int          alloc_results
);

    // predictor state
    logic [15:0] slot_codes [SLOTS];
    int unsigned filled;
    int unsigned rr_ptr;
    logic [7:0]  seq_bytes [4];
    int unsigned seq_have;
    int unsigned seq_need;

    result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic result_t raw_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    // append one expected result at the tail
    task automatic add_expected(input result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // slot lookup, allocation and jamo index split
    task automatic map_syllable(input logic [20:0] cp);
        result_t     r;
        int unsigned idx;
        int unsigned base;
        int unsigned fin;
        int unsigned vow;
        int unsigned ini;
        bit          hit;
        r = '0;
        hit = 0;
        idx = 0;
        for (int i = 0; i < filled && i < SLOTS; i++)
        begin
            if (!hit && slot_codes[i] == cp[15:0])
            begin
                idx = i;
                hit = 1;
            end
        end
        if (!hit)
        begin
            if (filled < SLOTS)
            begin
                idx = filled;
                filled++;
            end
            else
            begin
                idx = rr_ptr % SLOTS;
                rr_ptr = (idx + 1) % SLOTS;
            end
            slot_codes[idx] = cp[15:0];
            base = cp - HANGUL_FIRST;
            fin = base % 28;
            vow = (base / 28) % 21;
            ini = base / 588;
            r.newly_allocated = 1'b1;
            r.onset_index = 5'(ini + 2);
            r.onset_variant = 3'(VOWEL_CLASS[vow] + (fin != 0 ? 3 : 0));
            r.nucleus_set = (fin != 0);
            r.nucleus_index = VOWEL_LOOKUP[vow];
            r.coda_index = FINAL_LOOKUP[fin];
        end
        r.out_byte = 8'((FIRST_SLOT + idx) & 8'hFF);
        r.is_slot = 1'b1;
        r.code_point = cp[15:0];
        add_expected(r);
    endtask

    // work out the results that one request causes
    task automatic predict_request(input request_t req);
        int unsigned first;
        logic [20:0] cp;
        result_t     r;
        first = expected_results.size();
        case (op_t'(req.op))
            OP_QUERY:
            begin
                r = '0;
                r.out_byte = req.in_byte;
                if (req.in_byte >= FIRST_SLOT && (req.in_byte - FIRST_SLOT) < filled
                    && (req.in_byte - FIRST_SLOT) < SLOTS)
                    r.code_point = slot_codes[req.in_byte - FIRST_SLOT];
                add_expected(r);
            end
            OP_CLEAR:
            begin
                filled = 0;
                rr_ptr = 0;
                foreach (slot_codes[i]) slot_codes[i] = '0;
            end
            OP_TEXT:
            begin
                if (seq_have == 0)
                    seq_need = lead_need(req.in_byte);
                seq_bytes[seq_have & 3] = req.in_byte;
                seq_have++;
                if (seq_have >= seq_need)
                begin
                    case (seq_need)
                        2: cp = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
                        3: cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0],
                                 seq_bytes[2][5:0]};
                        4: cp = {seq_bytes[0][2:0], seq_bytes[1][5:0],
                                 seq_bytes[2][5:0], seq_bytes[3][5:0]};
                        default: cp = {13'd0, seq_bytes[0]};
                    endcase
                    if (cp >= HANGUL_FIRST && cp <= HANGUL_LAST)
                        map_syllable(cp);
                    else
                        for (int i = 0; i < seq_need; i++)
                            add_expected(raw_result(seq_bytes[i]));
                    seq_have = 0;
                    seq_need = 0;
                end
                else if (req.end_of_string)
                begin
                    // cut-off sequence flushes its bytes raw
                    for (int i = 0; i < seq_have; i++)
                        add_expected(raw_result(seq_bytes[i]));
                    seq_have = 0;
                    seq_need = 0;
                end
            end
            default: ;
        endcase
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled = 0;
            rr_ptr = 0;
            seq_have = 0;
            seq_need = 0;
            fail_count <= 0;
            slot_results <= 0;
            alloc_results <= 0;
            foreach (slot_codes[i]) slot_codes[i] = '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, res_payload);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (expected_results[0] !== res_payload)
                    begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, expected_results[0], res_payload);
                        fail_count <= fail_count + 1;
                    end
                    if (expected_results[0].is_slot)
                        slot_results <= slot_results + 1;
                    if (expected_results[0].newly_allocated)
                        alloc_results <= alloc_results + 1;
                    void'(expected_results.pop_front());
                end
            end
            if (req_valid && req_ready)
                predict_request(req_payload);
        end
    end

endmodule

// File: dv/hangul_glyph_slot_mapper_tb.sv
// testbench top: stimulus for the hangul glyph slot mapper and the verdict
`timescale 1ns / 100ps
module hangul_glyph_slot_mapper_tb;
    import hgsm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   slot_results;
    int   alloc_results;
    int   cycle_count;
    int   sent_count;

    hgsm_req_if request ();
    hgsm_res_if result ();

    hangul_glyph_slot_mapper u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    hgsm_slot_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (request.valid),
        .req_ready     (request.ready),
        .req_payload   (request.payload),
        .res_valid     (result.valid),
        .res_ready     (result.ready),
        .res_payload   (result.payload),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .slot_results  (slot_results),
        .alloc_results (alloc_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver stalls, a fresh wait drawn for every result
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            repeat (stall) @(posedge clk);
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            result.ready <= 1'b0;
        end
    end

    // send one request with a random gap in front
    task automatic send_request(input op_t op, input logic [7:0] b, input logic eos);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(posedge clk);
        request.valid <= 1'b1;
        request.payload <= '{op: op, in_byte: b, end_of_string: eos};
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        request.valid <= 1'b0;
        sent_count++;
    endtask

    // one syllable as three utf-8 bytes
    task automatic send_syllable(input logic [15:0] cp, input logic eos);
        send_request(OP_TEXT, {4'hE, cp[15:12]}, 1'b0);
        send_request(OP_TEXT, {2'b10, cp[11:6]}, 1'b0);
        send_request(OP_TEXT, {2'b10, cp[5:0]}, eos);
    endtask

    function automatic logic [15:0] rand_syllable(input int pool);
        if (pool > 0)
            return 16'(HANGUL_FIRST + $urandom_range(0, pool - 1));
        return 16'(HANGUL_FIRST + $urandom_range(0, 11171));
    endfunction

    // stimulus
    initial
    begin
        int kind;
        int pool;
        sent_count = 0;
        request.valid <= 1'b0;
        request.payload <= '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every op, cut-off, zero byte, hit, query, clear
        send_request(OP_QUERY, 8'd151, 1'b0);
        send_request(OP_TEXT, 8'h00, 1'b0);
        send_request(OP_TEXT, 8'h7F, 1'b1);
        send_syllable(16'hAC00, 1'b0);
        send_syllable(16'hD7A3, 1'b0);
        send_syllable(16'hAC00, 1'b1);
        send_request(OP_TEXT, 8'hFF, 1'b0);
        send_request(OP_TEXT, 8'h80, 1'b0);
        send_request(OP_TEXT, 8'hC3, 1'b0);
        send_request(OP_TEXT, 8'hA9, 1'b0);
        send_request(OP_TEXT, 8'hF0, 1'b0);
        send_request(OP_QUERY, 8'd152, 1'b0);
        send_request(OP_TEXT, 8'h9F, 1'b1);
        send_request(OP_QUERY, 8'd255, 1'b0);
        send_request(OP_QUERY, 8'd0, 1'b1);
        send_request(OP_NONE, 8'h55, 1'b0);
        send_request(OP_CLEAR, 8'hAA, 1'b0);
        send_request(OP_QUERY, 8'd151, 1'b0);

        // random: mostly syllables, mixed with raw bytes, cut-off sequences, queries and clears
        while (sent_count < 208)
        begin
            kind = $urandom_range(0, 19);
            pool = ($urandom_range(0, 1) == 0) ? 140 : 0;
            if (kind < 11)
                send_syllable(rand_syllable(pool), 1'($urandom_range(0, 1)));
            else if (kind < 13)
                send_request(OP_TEXT, 8'($urandom), 1'($urandom_range(0, 1)));
            else if (kind < 14)
            begin
                send_request(OP_TEXT, 8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
                send_request(OP_TEXT, 8'($urandom), 1'b1);
            end
            else if (kind < 15)
            begin
                send_request(OP_TEXT, 8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
                repeat (3) send_request(OP_TEXT, 8'($urandom), 1'b0);
            end
            else if (kind < 19)
                send_request(OP_QUERY, 8'($urandom), 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 5) == 0)
                send_request(OP_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
            else
                send_request(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        send_request(OP_TEXT, 8'h20, 1'b1);

        // drain, then allow for the longest search
        while (pending_count != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("tb: %0d requests sent, %0d slot results, %0d new allocations",
                 sent_count, slot_results, alloc_results);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
